// ===== hw/rtl/rwrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rwrs_pkg: shared types and constants for the ring window running sum
// Holds the operation codes, the fixed field widths and the record that
// carries one item from the position stage to the accumulate stage.
// ----------------------------------------------------------------------------
package rwrs_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W    = 32;
    localparam int OP_W        = 2;
    localparam int CFG_W       = 7;
    localparam int OUT_TDATA_W = 40;

    // Window length after reset.
    localparam logic [CFG_W-1:0] CFG_LENGTH_RESET = 7'd64;

    // Operation carried in the input tuser; the fourth code changes nothing.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // One item on its way to the accumulate stage.
    typedef struct packed {
        op_t                 op;
        logic [SAMPLE_W-1:0] sample;
        logic                hit;
        logic                full;
    } item_t;

endpackage

// ===== hw/rtl/rwrs_ram.sv =====
// ----------------------------------------------------------------------------
// rwrs_ram: generic single-clock RAM
// One write port and one read port with a registered read. A read and a
// write at the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module rwrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first port: the read takes the contents before this cycle's write.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/rwrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rwrs_ctrl: position stage of the ring window running sum
// Holds the window length, write position, full flag and entry valid marks.
// For each accepted beat it picks the entry to touch, drives the sample
// store and registers what the accumulate stage needs. After a window length
// write it folds the write position into the new length, one position bit a
// cycle, and holds the input side off until that is done.
// ----------------------------------------------------------------------------
module rwrs_ctrl
    import rwrs_pkg::*;
#(
    parameter int MAX_WINDOW = 64,
    localparam int PW = $clog2(MAX_WINDOW)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    input  logic                accept,
    input  op_t                 op,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                ready,
    output logic                ram_wr_en,
    output logic [PW-1:0]       ram_addr,
    output logic [SAMPLE_W-1:0] ram_wr_data,
    output item_t               item
);

    localparam int LW = PW + 1;
    localparam int CW = (LW > CFG_W) ? LW : CFG_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_WINDOW);

    logic [CFG_W-1:0]      window_length_reg;
    logic [PW-1:0]         pos_reg;
    logic [PW-1:0]         pos_next;
    logic [PW-1:0]         fold_reg;
    logic [PW-1:0]         fold_next;
    logic                  busy_reg;
    logic [LW-1:0]         rem_reg;
    logic [PW-1:0]         mask_reg;
    logic                  full_reg;
    logic                  full_next;
    logic [MAX_WINDOW-1:0] valid_reg;
    logic [MAX_WINDOW-1:0] valid_next;
    item_t                 item_reg;

    logic [CW-1:0]         len_wide;
    logic [LW-1:0]         len;
    logic [LW-1:0]         len_m1;
    logic [PW-1:0]         pos;
    logic [PW-1:0]         prev;
    logic [LW-1:0]         pos_inc;
    logic                  wrap;
    logic [PW-1:0]         addr;
    logic                  do_write;
    logic [LW-1:0]         rem_shift;
    logic [LW-1:0]         rem_step;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= CFG_LENGTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            window_length_reg <= cfg_wr_data;
        end
    end

    // Effective length: zero acts as one, anything above the store depth
    // acts as the depth.
    always_comb
    begin
        len_wide = CW'(window_length_reg);
        if (len_wide == '0)
        begin
            len_wide = CW'(1);
        end
        else if (len_wide > MAX_C)
        begin
            len_wide = MAX_C;
        end
    end

    assign len     = len_wide[LW-1:0];
    assign len_m1  = len - LW'(1);
    assign pos     = fold_reg;
    assign pos_inc = {1'b0, pos} + LW'(1);
    assign wrap    = (pos_inc >= len);
    assign prev    = (pos == '0) ? len_m1[PW-1:0] : pos - PW'(1);

    // One restoring remainder step of the write position by the length.
    assign rem_shift = {rem_reg[PW-1:0], |(pos_reg & mask_reg)};
    assign rem_step  = (rem_shift >= len) ? rem_shift - len : rem_shift;

    // Fold sequencer: starts on a length write, walks the position bits from
    // the top and stalls the input until the last bit is in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rem_reg  <= '0;
            mask_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            busy_reg <= 1'b1;
            rem_reg  <= '0;
            mask_reg <= PW'(1) << (PW - 1);
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_step;
            mask_reg <= mask_reg >> 1;
            if (mask_reg[0])
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign ready = ~busy_reg;

    // Per-operation position, flag and valid mark updates.
    always_comb
    begin
        pos_next    = pos_reg;
        fold_next   = fold_reg;
        full_next   = full_reg;
        valid_next  = valid_reg;
        addr        = pos;
        do_write    = 1'b0;
        ram_wr_data = sample;
        unique case (op)
            OP_INSERT:
            begin
                do_write        = 1'b1;
                pos_next        = wrap ? '0 : pos_inc[PW-1:0];
                fold_next       = pos_next;
                full_next       = full_reg | wrap;
                valid_next[pos] = 1'b1;
            end
            OP_DELETE:
            begin
                addr             = prev;
                do_write         = 1'b1;
                ram_wr_data      = '0;
                pos_next         = prev;
                fold_next        = prev;
                valid_next[prev] = 1'b1;
            end
            OP_CLEAR:
            begin
                pos_next   = '0;
                fold_next  = '0;
                full_next  = 1'b0;
                valid_next = '0;
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    // Control state moves on each accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            full_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            full_reg  <= full_next;
            valid_reg <= valid_next;
        end
    end

    // Position within the current length: loaded by the fold sequencer and
    // kept in step with the write position by each accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_reg <= '0;
        end
        else if (busy_reg && mask_reg[0])
        begin
            fold_reg <= rem_step[PW-1:0];
        end
        else if (accept)
        begin
            fold_reg <= fold_next;
        end
    end

    // Item record for the accumulate stage, aligned with the RAM read data.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op     <= op;
            item_reg.sample <= sample;
            item_reg.hit    <= valid_reg[addr];
            item_reg.full   <= full_next;
        end
    end

    assign ram_wr_en = accept & do_write;
    assign ram_addr  = addr;
    assign item      = item_reg;

endmodule

// ===== hw/rtl/rwrs_accum.sv =====
// ----------------------------------------------------------------------------
// rwrs_accum: accumulate and output stage of the ring window running sum
// Combines the old entry read from the store with the item record to update
// the running total, and holds the result beat until the sink takes it.
// ----------------------------------------------------------------------------
module rwrs_accum
    import rwrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  item_t               item,
    input  logic [SAMPLE_W-1:0] rd_data,
    input  logic                out_ready,
    output logic                in_ready,
    output logic                out_valid,
    output logic [SAMPLE_W-1:0] total,
    output logic                full
);

    logic                b_valid_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] total_reg;
    logic [SAMPLE_W-1:0] total_next;
    logic                full_reg;
    logic [SAMPLE_W-1:0] old;
    logic                advance;

    // The item in this stage moves on when the output register is free.
    assign advance  = b_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~b_valid_reg | advance;

    // Entries never written since the last clear read as zero.
    assign old = item.hit ? rd_data : '0;

    // Running total after this operation, wrapping at 32 bits.
    always_comb
    begin
        unique case (item.op)
            OP_INSERT: total_next = total_reg + item.sample - (item.full ? old : '0);
            OP_DELETE: total_next = total_reg - old;
            OP_CLEAR:  total_next = '0;
            default:   total_next = total_reg;
        endcase
    end

    // Pipeline valids and the running total.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                b_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= total_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Full flag travels with the result beat.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            full_reg <= item.full;
        end
    end

    assign out_valid = out_valid_reg;
    assign total     = total_reg;
    assign full      = full_reg;

endmodule

// ===== hw/rtl/ring_window_running_sum_top.sv =====
// ----------------------------------------------------------------------------
// ring_window_running_sum_top: moving window sum over a circular store
// Inserts, deletes and clears samples in a ring of configurable length and
// reports the running total and full flag after every operation.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle for as long as the result side is
// ready and no length fold is in progress, and every input beat gives exactly
// one result beat. The input beat is registered into the item record and the
// sample store's registered read port, and then into the output register: the
// position stage reads and writes the entry in the cycle of acceptance, and
// the accumulate stage folds the old entry into the total once the output
// register is free. A stalled result holds one item in each stage, after which
// the input side stops. The window length may only be changed while no beat
// is in flight; after each length write the input side stays not ready while
// the write position is folded into the new length one bit a cycle. Clear
// needs no sweep, as the entry valid marks are cleared at once.
module ring_window_running_sum_top
    import rwrs_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration: window_length.
    input  logic                   cfg_wr_en,
    input  logic [CFG_W-1:0]       cfg_wr_data,
    // Input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SAMPLE_W-1:0]    s_axis_tdata,   // [31:0] sample_value
    input  logic [OP_W-1:0]        s_axis_tuser,   // [1:0] operation
    // Result stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [31:0] window_total,
                                                   // [32] window_full, rest zero
);

    localparam int PW = $clog2(MAX_WINDOW);

    logic                accept;
    logic                ctrl_ready;
    logic                accum_ready;
    logic                ram_wr_en;
    logic [PW-1:0]       ram_addr;
    logic [SAMPLE_W-1:0] ram_wr_data;
    logic [SAMPLE_W-1:0] ram_rd_data;
    item_t               item;
    logic [SAMPLE_W-1:0] total;
    logic                full;

    assign s_axis_tready = ctrl_ready & accum_ready;
    assign accept        = s_axis_tvalid & s_axis_tready;

    // Position stage.
    rwrs_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .op          (op_t'(s_axis_tuser)),
        .sample      (s_axis_tdata),
        .ready       (ctrl_ready),
        .ram_wr_en   (ram_wr_en),
        .ram_addr    (ram_addr),
        .ram_wr_data (ram_wr_data),
        .item        (item)
    );

    // Sample store.
    rwrs_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (ram_addr),
        .rd_data (ram_rd_data)
    );

    // Accumulate and output stage.
    rwrs_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .rd_data   (ram_rd_data),
        .out_ready (m_axis_tready),
        .in_ready  (accum_ready),
        .out_valid (m_axis_tvalid),
        .total     (total),
        .full      (full)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - SAMPLE_W - 1)'(0), full, total};

endmodule

// ===== hw/rtl/rwrs_checker.sv =====
// ----------------------------------------------------------------------------
// rwrs_checker: port-level checks for the ring window running sum
// Watches the stream ports for held results, beat accounting and padding,
// and is bound to the top level.
// ----------------------------------------------------------------------------
module rwrs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    logic       in_beat;
    logic       out_beat;
    logic [1:0] inflight_reg;

    assign in_beat  = s_axis_tvalid & s_axis_tready;
    assign out_beat = m_axis_tvalid & m_axis_tready;

    // Beats accepted but not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 2'd0;
        end
        else if (in_beat && !out_beat)
        begin
            inflight_reg <= inflight_reg + 2'd1;
        end
        else if (out_beat && !in_beat)
        begin
            inflight_reg <= inflight_reg - 2'd1;
        end
    end

    // A stalled result beat keeps its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // No result beat without an accepted input beat behind it.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> inflight_reg != 2'd0)
        else $error("result beat without an input beat");

    // No more than two beats in flight.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == 2'd2 && !out_beat |-> !in_beat)
        else $error("more than two beats in flight");

    // Padding above the full flag is zero.
    a_padding: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
        else $error("result padding not zero");

endmodule

bind ring_window_running_sum_top rwrs_checker u_rwrs_checker (.*);
